[rtl/crh_pkg.sv]
// shared types and constants for the content-range header parser
// no dependencies; every rtl file refers to this package by scoped names

package crh_pkg;

    localparam int VALUE_WIDTH = 40;

    localparam logic [VALUE_WIDTH-1:0] SENTINEL = {VALUE_WIDTH{1'b1}};
    localparam logic [VALUE_WIDTH-1:0] SAT_MAX  = SENTINEL - VALUE_WIDTH'(1);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] SLASH_NONE = 2'd0;
    localparam logic [1:0] SLASH_ONE  = 2'd1;
    localparam logic [1:0] SLASH_MANY = 2'd2;

    typedef enum logic [1:0] {
        TP_SKIP_WS = 2'd0,
        TP_DIGITS  = 2'd1,
        TP_STOPPED = 2'd2
    } t_total_phase;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] first_pos;
        logic [VALUE_WIDTH-1:0] last_pos;
        logic [VALUE_WIDTH-1:0] total_len;
        logic                   format_error;
    } t_out_item;

endpackage

[rtl/crh_acc.sv]
// decimal accumulate step: acc * 10 + digit, saturating one below all ones
// depends on crh_pkg

module crh_acc (
    input  logic [crh_pkg::VALUE_WIDTH-1:0] i_acc,
    input  logic [3:0]                      i_digit,
    output logic [crh_pkg::VALUE_WIDTH-1:0] o_acc
);

    localparam int WW = crh_pkg::VALUE_WIDTH + 4;

    logic [WW-1:0] wide;
    logic [WW-1:0] acc_ext;

    // times ten as shift-and-add, fits since acc never exceeds the sentinel
    assign acc_ext = WW'(i_acc);
    assign wide    = (acc_ext << 3) + (acc_ext << 1) + WW'(i_digit);
    assign o_acc   = (wide > WW'(crh_pkg::SAT_MAX)) ? crh_pkg::SAT_MAX
                                                    : wide[crh_pkg::VALUE_WIDTH-1:0];

endmodule

[rtl/crh_parser.sv]
// parse state registers, per-byte next-state logic and result formation
// depends on crh_pkg and crh_acc

module crh_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  crh_pkg::t_in_item i_item,
    output crh_pkg::t_out_item o_result
);

    localparam int VW = crh_pkg::VALUE_WIDTH;

    logic [1:0]            r_slash_count, n_slash_count;
    logic                  r_dash_seen, n_dash_seen;
    logic [VW-1:0]         r_begin_value, n_begin_value;
    logic [VW-1:0]         r_digit_accum, n_digit_accum;
    logic                  r_digits_present, n_digits_present;
    crh_pkg::t_total_phase r_total_phase, n_total_phase;
    logic [VW-1:0]         r_total_accum, n_total_accum;
    logic                  r_star_only, n_star_only;

    logic [7:0]    c;
    logic          is_digit;
    logic          is_ws;
    logic [3:0]    digit_val;
    logic [VW-1:0] range_acc;
    logic [VW-1:0] total_acc;
    logic [VW-1:0] num;

    assign c         = i_item.char_byte;
    assign is_digit  = (c >= crh_pkg::CH_ZERO) && (c <= crh_pkg::CH_NINE);
    assign is_ws     = (c == crh_pkg::CH_SPACE) ||
                       ((c >= crh_pkg::CH_TAB) && (c <= crh_pkg::CH_CR));
    assign digit_val = c[3:0];

    crh_acc u_range_acc (
        .i_acc   (r_digit_accum),
        .i_digit (digit_val),
        .o_acc   (range_acc)
    );

    crh_acc u_total_acc (
        .i_acc   (r_total_accum),
        .i_digit (digit_val),
        .o_acc   (total_acc)
    );

    always_comb begin
        n_slash_count    = r_slash_count;
        n_dash_seen      = r_dash_seen;
        n_begin_value    = r_begin_value;
        n_digit_accum    = r_digit_accum;
        n_digits_present = r_digits_present;
        n_total_phase    = r_total_phase;
        n_total_accum    = r_total_accum;
        n_star_only      = r_star_only;

        if (c == crh_pkg::CH_SLASH) begin
            if (r_slash_count != crh_pkg::SLASH_MANY) begin
                n_slash_count = r_slash_count + 2'd1;
            end
        end else if (r_slash_count == crh_pkg::SLASH_NONE) begin
            if (is_digit) begin
                n_digit_accum    = range_acc;
                n_digits_present = 1'b1;
            end else if (c == crh_pkg::CH_DASH && !r_dash_seen) begin
                n_begin_value    = r_digits_present ? r_digit_accum : crh_pkg::SENTINEL;
                n_dash_seen      = 1'b1;
                n_digit_accum    = '0;
                n_digits_present = 1'b0;
            end
        end else if (r_slash_count == crh_pkg::SLASH_ONE) begin
            if (!is_ws) begin
                // anything after a lone star turns the total into zero
                if (r_star_only) begin
                    n_star_only = 1'b0;
                end else if (r_total_phase == crh_pkg::TP_SKIP_WS &&
                             c == crh_pkg::CH_STAR) begin
                    n_star_only   = 1'b1;
                    n_total_phase = crh_pkg::TP_STOPPED;
                end else if (r_total_phase != crh_pkg::TP_STOPPED && is_digit) begin
                    n_total_accum = total_acc;
                    n_total_phase = crh_pkg::TP_DIGITS;
                end else begin
                    n_total_phase = crh_pkg::TP_STOPPED;
                end
            end else if (r_total_phase == crh_pkg::TP_DIGITS) begin
                n_total_phase = crh_pkg::TP_STOPPED;
            end
        end
    end

    // result reflects the state after the final byte
    always_comb begin
        num = n_digits_present ? n_digit_accum : crh_pkg::SENTINEL;
        if (n_slash_count != crh_pkg::SLASH_ONE) begin
            o_result.first_pos    = crh_pkg::SENTINEL;
            o_result.last_pos     = crh_pkg::SENTINEL;
            o_result.total_len    = crh_pkg::SENTINEL;
            o_result.format_error = 1'b1;
        end else begin
            o_result.first_pos    = n_dash_seen ? n_begin_value : num;
            o_result.last_pos     = n_dash_seen ? num : crh_pkg::SENTINEL;
            o_result.total_len    = n_star_only ? crh_pkg::SENTINEL : n_total_accum;
            o_result.format_error = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.is_last)) begin
            r_slash_count    <= crh_pkg::SLASH_NONE;
            r_dash_seen      <= 1'b0;
            r_begin_value    <= crh_pkg::SENTINEL;
            r_digit_accum    <= '0;
            r_digits_present <= 1'b0;
            r_total_phase    <= crh_pkg::TP_SKIP_WS;
            r_total_accum    <= '0;
            r_star_only      <= 1'b0;
        end else if (i_step) begin
            r_slash_count    <= n_slash_count;
            r_dash_seen      <= n_dash_seen;
            r_begin_value    <= n_begin_value;
            r_digit_accum    <= n_digit_accum;
            r_digits_present <= n_digits_present;
            r_total_phase    <= n_total_phase;
            r_total_accum    <= n_total_accum;
            r_star_only      <= n_star_only;
        end
    end

endmodule

[rtl/content_range_header_parser_core.sv]
// Content-Range value parser, top level: input register, parser, result register.
// One byte is taken per cycle and one byte is processed per cycle while the input
// is not stalled; a result goes from the input register into the result register.
// The decimal accumulates (times ten plus digit, saturating) are loops in the
// parser stage, one step per byte. The input stalls only when a last byte
// waits for a result register that holds an untaken result.
// Depends on crh_pkg, crh_parser and crh_acc.

module content_range_header_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  crh_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output crh_pkg::t_out_item o_out_data
);

    logic               r_in_valid;
    crh_pkg::t_in_item  r_in;
    logic               r_out_valid;
    crh_pkg::t_out_item r_out;
    crh_pkg::t_out_item result;
    logic               step;
    logic               in_xfer;

    // a non-last byte never needs the result register
    assign step = r_in_valid && (!r_in.is_last || !r_out_valid || !i_out_stall);

    assign o_in_stall  = r_in_valid && !step;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    crh_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.is_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.is_last) begin
            r_out <= result;
        end
    end

endmodule

[rtl/crh_checker.sv]
// port-level checks for the content-range header parser, bound to the top level
// depends on crh_pkg and content_range_header_parser_core

module crh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input crh_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input crh_pkg::t_out_item o_out_data
);

    // a stalled input transfer keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while stalled");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // with the result register empty the input side never stalls
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    // a bad slash count reports every value as absent
    a_error_sentinels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.format_error |->
            o_out_data.first_pos == crh_pkg::SENTINEL &&
            o_out_data.last_pos == crh_pkg::SENTINEL &&
            o_out_data.total_len == crh_pkg::SENTINEL)
        else $error("format error without sentinel values");

    // the input stalls only while a result is held by an output stall
    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

endmodule

bind content_range_header_parser_core crh_checker u_crh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
